>>> sv/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants of the sorted key table
// Field widths, status codes and the control word that is broadcast to
// the cell row.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int unsigned KeyW    = 32;
  localparam int unsigned ValW    = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  // Action codes
  localparam logic ActInsert = 1'b0;
  localparam logic ActRemove = 1'b1;

  // Status codes
  localparam logic [StatusW-1:0] StDone     = 2'd0;
  localparam logic [StatusW-1:0] StDup      = 2'd1;
  localparam logic [StatusW-1:0] StNotFound = 2'd2;
  localparam logic [StatusW-1:0] StFull     = 2'd3;

  // Update command for the cell row, valid for one cycle
  typedef struct packed {
    logic ins;  // open a slot at the insert point, shift the rest up
    logic rem;  // close the slot of the hit entry, shift the rest down
  } skt_ctrl_t;

endpackage

>>> sv/skt_if.sv
// ----------------------------------------------------------------------------
// skt_in_if / skt_out_if: valid/ready channels of the sorted key table
// Request channel carries the action and the pair, response channel the
// status, removed value and entry count.
// ----------------------------------------------------------------------------
interface skt_in_if
  import skt_pkg::*;
();
  logic              valid;
  logic              ready;
  logic              action;
  logic [KeyW-1:0]   key;
  logic [ValW-1:0]   entry_value;

  modport source (output valid, action, key, entry_value, input ready);
  modport sink   (input valid, action, key, entry_value, output ready);
endinterface

interface skt_out_if
  import skt_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [StatusW-1:0] status;
  logic [ValW-1:0]    removed_value;
  logic [CountW-1:0]  entry_count;

  modport source (output valid, status, removed_value, entry_count, input ready);
  modport sink   (input valid, status, removed_value, entry_count, output ready);
endinterface

>>> sv/skt_cell.sv
// ----------------------------------------------------------------------------
// skt_cell: one slot of the sorted key row
// Holds a key/value pair, compares it against the request key and, on an
// update, keeps its pair, loads the new pair or takes a neighbor's pair.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  // compare phase
  input  logic            cmp_en_i,
  input  logic            occupied_i,
  input  logic [KeyW-1:0] cmp_key_i,
  // update phase
  input  skt_ctrl_t       ctrl_i,
  input  logic [ValW-1:0] new_value_i,
  input  logic            left_lt_i,
  input  logic [KeyW-1:0] left_key_i,
  input  logic [ValW-1:0] left_value_i,
  input  logic [KeyW-1:0] right_key_i,
  input  logic [ValW-1:0] right_value_i,
  // state towards neighbors and the top
  output logic [KeyW-1:0] key_o,
  output logic [ValW-1:0] value_o,
  output logic            lt_o,
  output logic            eq_o
);

  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] value_q, value_d;
  logic            lt_q, lt_d;
  logic            eq_q, eq_d;

  // Compare against the request key; flags are held for the update cycle
  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (cmp_en_i) begin
      lt_d = occupied_i && ($signed(key_q) < $signed(cmp_key_i));
      eq_d = occupied_i && (key_q == cmp_key_i);
    end
  end

  // Slot update: entries below the insert/remove point stay put
  always_comb begin
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.ins && !lt_q) begin
      if (left_lt_i) begin
        key_d   = cmp_key_i;
        value_d = new_value_i;
      end else begin
        key_d   = left_key_i;
        value_d = left_value_i;
      end
    end else if (ctrl_i.rem && !lt_q) begin
      key_d   = right_key_i;
      value_d = right_value_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q <= 1'b0;
      eq_q <= 1'b0;
    end else begin
      lt_q <= lt_d;
      eq_q <= eq_d;
    end
  end

  // Pair storage, no reset
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

  assign key_o   = key_q;
  assign value_o = value_q;
  assign lt_o    = lt_q;
  assign eq_o    = eq_q;

endmodule

>>> sv/sorted_key_table.sv
// ----------------------------------------------------------------------------
// sorted_key_table: key/value table kept in ascending signed key order
// A row of CAPACITY cells; insert opens a slot at the sorted position,
// remove closes the slot of the matching key and returns its value.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_i     in   valid/ready    action, key, entry_value
//  out_o    out  valid/ready    status, removed_value, entry_count
//
//  Per transaction, the accept edge registers the compare flags of every
//  cell; the update then shifts the cell row and loads the response
//  register. The next request is taken only after the update, so the
//  table takes no new request while one is in flight.
//  If the response register is still full, the update waits for out_o.ready.
//  Reset clears the occupancy count and the control state; slots need no clear.
// ----------------------------------------------------------------------------
module sorted_key_table
  import skt_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  skt_in_if.sink    in_i,
  skt_out_if.source out_o
);

  localparam int unsigned OccW = $clog2(CAPACITY + 1);

  logic [OccW-1:0]    occ_q, occ_d;
  logic               busy_q, busy_d;
  logic               action_q;
  logic [KeyW-1:0]    key_q;
  logic [ValW-1:0]    value_q;
  logic               out_valid_q, out_valid_d;
  logic [StatusW-1:0] status_q, status_d;
  logic [ValW-1:0]    removed_q, removed_d;
  logic [CountW-1:0]  count_q, count_d;

  logic               accept;
  logic               update;
  logic               hit;
  logic               full;
  logic [ValW-1:0]    hit_value;
  skt_ctrl_t          ctrl;
  logic [KeyW-1:0]    cmp_key;

  logic [KeyW-1:0]    cell_key   [CAPACITY];
  logic [ValW-1:0]    cell_value [CAPACITY];
  logic [CAPACITY-1:0] cell_lt;
  logic [CAPACITY-1:0] cell_eq;

  assign in_i.ready = !busy_q;
  assign accept     = in_i.valid && in_i.ready;
  assign update     = busy_q && (!out_valid_q || out_o.ready);

  // Request key goes straight to the cells on accept, then is held
  assign cmp_key = accept ? in_i.key : key_q;

  // Cell row
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic            left_lt;
    logic [KeyW-1:0] left_key, right_key;
    logic [ValW-1:0] left_value, right_value;

    if (i == 0) begin : g_first
      assign left_lt    = 1'b1;
      assign left_key   = cell_key[i];
      assign left_value = cell_value[i];
    end else begin : g_mid_l
      assign left_lt    = cell_lt[i-1];
      assign left_key   = cell_key[i-1];
      assign left_value = cell_value[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_key   = cell_key[i];
      assign right_value = cell_value[i];
    end else begin : g_mid_r
      assign right_key   = cell_key[i+1];
      assign right_value = cell_value[i+1];
    end

    skt_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmp_en_i     (accept),
      .occupied_i   (OccW'(i) < occ_q),
      .cmp_key_i    (cmp_key),
      .ctrl_i       (ctrl),
      .new_value_i  (value_q),
      .left_lt_i    (left_lt),
      .left_key_i   (left_key),
      .left_value_i (left_value),
      .right_key_i  (right_key),
      .right_value_i(right_value),
      .key_o        (cell_key[i]),
      .value_o      (cell_value[i]),
      .lt_o         (cell_lt[i]),
      .eq_o         (cell_eq[i])
    );
  end

  // Hit detection and value of the matching slot (at most one match)
  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_eq[i]) hit_value = hit_value | cell_value[i];
    end
  end
  assign hit  = |cell_eq;
  assign full = (occ_q == OccW'(CAPACITY));

  // Update command and response
  always_comb begin
    ctrl        = '0;
    occ_d       = occ_q;
    status_d    = status_q;
    removed_d   = removed_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    busy_d      = busy_q;
    if (out_o.ready) out_valid_d = 1'b0;
    if (accept) busy_d = 1'b1;
    if (update) begin
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
      status_d    = StDone;
      removed_d   = '0;
      if (action_q == ActInsert) begin
        if (hit) begin
          status_d = StDup;
        end else if (full) begin
          status_d = StFull;
        end else begin
          ctrl.ins = 1'b1;
          occ_d    = occ_q + OccW'(1);
        end
      end else begin
        if (!hit) begin
          status_d = StNotFound;
        end else begin
          ctrl.rem  = 1'b1;
          removed_d = hit_value;
          occ_d     = occ_q - OccW'(1);
        end
      end
      count_d = CountW'(occ_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q       <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      occ_q       <= occ_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload, no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      action_q <= in_i.action;
      key_q    <= in_i.key;
      value_q  <= in_i.entry_value;
    end
    status_q  <= status_d;
    removed_q <= removed_d;
    count_q   <= count_d;
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.status        = status_q;
  assign out_o.removed_value = removed_q;
  assign out_o.entry_count   = count_q;

endmodule
